// ===== design/pes_pkg.sv =====
`default_nettype none

package pes_pkg;

    // Fixed field widths of the channels.
    localparam int CHAR_W   = 8;
    localparam int RES_W    = 32;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // ASCII codes of the expression alphabet.
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd3;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_POW
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== design/pes_stk.sv =====
`default_nettype none

module pes_stk #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr0,
    input  logic [AW-1:0]    rd_addr1,
    output logic [WIDTH-1:0] rd_data0,
    output logic [WIDTH-1:0] rd_data1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

`default_nettype wire

// ===== design/pes_alu.sv =====
`default_nettype none

module pes_alu #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pes_pkg::alu_req_t req,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    import pes_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIX,
        S_PCHK,
        S_PRES,
        S_PBASE
    } alu_state_t;

    alu_state_t       state_reg, state_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] result_reg, result_next;

    // Datapath: acc holds the product or the remainder, mc the multiplicand or
    // the dividend/quotient, mp the multiplier or the divisor.
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] mc_reg, mc_next;
    logic [WIDTH-1:0] mp_reg, mp_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             neg_reg, neg_next;

    // The adder that all operations share.
    logic [WIDTH-1:0] add_a, add_b;
    logic             add_cin;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] rem_shift;
    logic [WIDTH-1:0] a_mag, b_mag;

    assign rem_shift = {acc_reg[WIDTH-2:0], mc_reg[WIDTH-1]};
    assign a_mag     = a[WIDTH-1] ? ('0 - a) : a;
    assign b_mag     = b[WIDTH-1] ? ('0 - b) : b;

    always_comb
    begin
        add_a   = acc_reg;
        add_b   = mp_reg[0] ? mc_reg : '0;
        add_cin = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                add_a   = a;
                add_b   = (req.op == ALU_SUB) ? ~b : b;
                add_cin = (req.op == ALU_SUB);
            end
            S_DIV:
            begin
                add_a   = rem_shift;
                add_b   = ~mp_reg;
                add_cin = 1'b1;
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = mp_reg[0] ? mc_reg : '0;
                add_cin = 1'b0;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, add_b} + (WIDTH + 1)'(add_cin);
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        acc_next    = acc_reg;
        mc_next     = mc_reg;
        mp_next     = mp_reg;
        base_next   = base_reg;
        res_next    = res_reg;
        exp_next    = exp_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    unique case (req.op)
                        ALU_ADD, ALU_SUB:
                        begin
                            result_next = sum[WIDTH-1:0];
                            done_next   = 1'b1;
                        end
                        ALU_MUL:
                        begin
                            acc_next   = '0;
                            mc_next    = a;
                            mp_next    = b;
                            state_next = S_MUL;
                        end
                        ALU_DIV:
                        begin
                            acc_next   = '0;
                            mc_next    = a_mag;
                            mp_next    = b_mag;
                            neg_next   = a[WIDTH-1] ^ b[WIDTH-1];
                            cnt_next   = CW'(WIDTH);
                            state_next = S_DIV;
                        end
                        ALU_POW:
                        begin
                            if (b[WIDTH-1])
                            begin
                                // Negative exponent: only bases one and minus one survive.
                                done_next = 1'b1;
                                if (a == WIDTH'(1))
                                begin
                                    result_next = WIDTH'(1);
                                end
                                else if (a == '1)
                                begin
                                    result_next = b[0] ? '1 : WIDTH'(1);
                                end
                                else
                                begin
                                    result_next = '0;
                                end
                            end
                            else
                            begin
                                base_next  = a;
                                res_next   = WIDTH'(1);
                                exp_next   = b;
                                state_next = S_PCHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                if (mp_reg == '0)
                begin
                    result_next = acc_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    acc_next = sum[WIDTH-1:0];
                    mc_next  = mc_reg << 1;
                    mp_next  = mp_reg >> 1;
                end
            end
            S_DIV:
            begin
                acc_next = sum[WIDTH] ? sum[WIDTH-1:0] : rem_shift;
                mc_next  = {mc_reg[WIDTH-2:0], sum[WIDTH]};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                result_next = neg_reg ? ('0 - mc_reg) : mc_reg;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_PCHK:
            begin
                acc_next = '0;
                if (exp_reg == '0)
                begin
                    result_next = res_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (exp_reg[0])
                begin
                    mc_next    = res_reg;
                    mp_next    = base_reg;
                    state_next = S_PRES;
                end
                else
                begin
                    mc_next    = base_reg;
                    mp_next    = base_reg;
                    state_next = S_PBASE;
                end
            end
            S_PRES:
            begin
                if (mp_reg == '0)
                begin
                    res_next = acc_reg;
                    if (exp_reg[WIDTH-1:1] == '0)
                    begin
                        // Last exponent bit: the squaring would never be used.
                        result_next = acc_reg;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        acc_next   = '0;
                        mc_next    = base_reg;
                        mp_next    = base_reg;
                        state_next = S_PBASE;
                    end
                end
                else
                begin
                    acc_next = sum[WIDTH-1:0];
                    mc_next  = mc_reg << 1;
                    mp_next  = mp_reg >> 1;
                end
            end
            S_PBASE:
            begin
                if (mp_reg == '0)
                begin
                    base_next  = acc_reg;
                    exp_next   = exp_reg >> 1;
                    state_next = S_PCHK;
                end
                else
                begin
                    acc_next = sum[WIDTH-1:0];
                    mc_next  = mc_reg << 1;
                    mp_next  = mp_reg >> 1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mc_reg   <= mc_next;
        mp_reg   <= mp_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        exp_reg  <= exp_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/prefix_expression_stack_evaluator.sv =====
`default_nettype none

// Prefix expression evaluator. Characters of an expression of single digits and
// the operators + - * / ^ arrive right to left, one transaction each, and the
// leftmost one carries is_last. A digit is pushed onto the stack when it is
// accepted. An operator reads its two operands from the stack memory and runs
// on one shared iterative unit built around a shared adder: + and - finish in
// its idle state, * and / work one multiplier or quotient bit a cycle, and ^
// runs a square-and-multiply loop in which each square and each multiply is
// shift-and-add. The last character then passes through T_RD0 and T_FIN to read
// the bottom of the stack and gives one result: the value with status 0, or
// value 0 with status 1 (bad character or malformed), 2 (division by zero) or
// 3 (stack overflow). After the first error, characters are ignored until the
// last one. The block takes no new character while an item is at work; a
// finished result sits in an output register while the next expression starts.
module prefix_expression_stack_evaluator #(
    parameter int STACK_DEPTH = pes_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = pes_pkg::DEF_VALUE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              char_valid,
    output logic                              char_stall,
    input  logic [pes_pkg::CHAR_W-1:0]        character,
    input  logic                              is_last,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [pes_pkg::RES_W-1:0]  value,
    output logic [pes_pkg::STATUS_W-1:0]      status
);

    import pes_pkg::*;

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNTW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        T_IDLE,
        T_OPRD,
        T_ALU,
        T_RD0,
        T_FIN
    } top_state_t;

    top_state_t          state_reg, state_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    alu_op_t             op_reg, op_next;
    logic                last_reg, last_next;
    logic                res_valid_reg, res_valid_next;
    logic [RES_W-1:0]    value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                   accept;
    logic                   is_digit, is_oper;
    alu_op_t                char_op;
    logic [CNTW-1:0]        cnt_m1, cnt_m2;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr, rd_addr0, rd_addr1;
    logic [VALUE_WIDTH-1:0] wr_data, rd_data0, rd_data1;
    alu_req_t               alu_req;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;

    assign char_stall = (state_reg != T_IDLE);
    assign accept     = char_valid && !char_stall;
    assign cnt_m1     = cnt_reg - CNTW'(1);
    assign cnt_m2     = cnt_reg - CNTW'(2);

    always_comb
    begin
        is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
        is_oper  = 1'b1;
        char_op  = ALU_ADD;
        unique case (character)
            CH_PLUS:  char_op = ALU_ADD;
            CH_MINUS: char_op = ALU_SUB;
            CH_MUL:   char_op = ALU_MUL;
            CH_DIV:   char_op = ALU_DIV;
            CH_POW:   char_op = ALU_POW;
            default:  is_oper = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        res_valid_next = res_valid_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[AW-1:0];
        // The digit value is the low nibble of its ASCII code.
        wr_data        = VALUE_WIDTH'(character[3:0]);
        rd_addr0       = cnt_m1[AW-1:0];
        rd_addr1       = cnt_m2[AW-1:0];
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    last_next  = is_last;
                    state_next = is_last ? T_RD0 : T_IDLE;
                    if (err_reg == ST_OK)
                    begin
                        priority if (is_digit)
                        begin
                            if (cnt_reg == CNTW'(STACK_DEPTH))
                            begin
                                err_next = ST_OVF;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CNTW'(1);
                            end
                        end
                        else if (is_oper)
                        begin
                            if (cnt_reg < CNTW'(2))
                            begin
                                err_next = ST_BAD;
                            end
                            else
                            begin
                                op_next    = char_op;
                                state_next = T_OPRD;
                            end
                        end
                        else
                        begin
                            err_next = ST_BAD;
                        end
                    end
                end
            end
            T_OPRD:
            begin
                if ((op_reg == ALU_DIV) && (rd_data1 == '0))
                begin
                    err_next   = ST_DIVZ;
                    state_next = last_reg ? T_RD0 : T_IDLE;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = T_ALU;
                end
            end
            T_ALU:
            begin
                wr_addr = cnt_m2[AW-1:0];
                wr_data = alu_result;
                if (alu_done)
                begin
                    wr_en      = 1'b1;
                    cnt_next   = cnt_m1;
                    state_next = last_reg ? T_RD0 : T_IDLE;
                end
            end
            T_RD0:
            begin
                rd_addr0   = '0;
                state_next = T_FIN;
            end
            T_FIN:
            begin
                rd_addr0 = '0;
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    value_next     = '0;
                    if (err_reg != ST_OK)
                    begin
                        status_next = err_reg;
                    end
                    else if (cnt_reg == CNTW'(1))
                    begin
                        status_next = ST_OK;
                        value_next  = RES_W'(rd_data0);
                    end
                    else
                    begin
                        status_next = ST_BAD;
                    end
                    cnt_next   = '0;
                    err_next   = ST_OK;
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            op_reg        <= ALU_ADD;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            value_reg     <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            op_reg        <= op_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
            value_reg     <= value_next;
            status_reg    <= status_next;
        end
    end

    pes_stk #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_stk (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    pes_alu #(
        .WIDTH (VALUE_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (rd_data0),
        .b      (rd_data1),
        .done   (alu_done),
        .result (alu_result)
    );

    assign res_valid = res_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ===== design/pes_chk.sv =====
`default_nettype none

module pes_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          char_valid,
    input logic                          char_stall,
    input logic                          is_last,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [pes_pkg::RES_W-1:0]     value,
    input logic [pes_pkg::STATUS_W-1:0]  status
);

    import pes_pkg::*;

    // A waiting result holds until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(value) && $stable(status))
        else $error("result changed while stalled");

    // A failed evaluation never reports a value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status != ST_OK) |-> (value == '0))
        else $error("nonzero value with error status");

    // A result appears only after the last character's work is done, never on
    // the cycle right after a character transaction.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall |=> !$rose(res_valid))
        else $error("result raised right after a character transaction");

    // The last character always needs the final stack read, so the input stalls.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && is_last |=> char_stall)
        else $error("input not stalled after the last character");

endmodule

bind prefix_expression_stack_evaluator pes_chk u_pes_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .is_last    (is_last),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .value      (value),
    .status     (status)
);

`default_nettype wire

// ===== dv/prefix_expression_stack_evaluator_tb.sv =====
`default_nettype none

module prefix_expression_stack_evaluator_tb;

    import pes_pkg::*;

    localparam int DEPTH       = DEF_STACK_DEPTH;
    localparam int RAND_CHARS  = 720;
    localparam int DRAIN_EVERY = 200;
    localparam int TAIL_CYCLES = 64;
    localparam int LIMIT       = 10_000_000;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              drain;
    } char_item_t;

    typedef struct {
        logic [RES_W-1:0]    value;
        logic [STATUS_W-1:0] status;
    } eval_result_t;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    logic clk;
    logic rst_n;

    logic                       char_valid = 1'b0;
    logic                       char_stall;
    logic [CHAR_W-1:0]          character  = '0;
    logic                       is_last    = 1'b0;
    logic                       res_valid;
    logic                       res_stall  = 1'b0;
    logic signed [RES_W-1:0]    value;
    logic [STATUS_W-1:0]        status;

    char_item_t   pending_chars[$];
    eval_result_t expected_results[$];

    // Shadow of the evaluator state.
    logic [RES_W-1:0]    shadow_stack [DEPTH];
    int                  shadow_count = 0;
    logic [STATUS_W-1:0] shadow_error = ST_OK;

    int  errors       = 0;
    int  cycle_count  = 0;
    int  queued_chars = 0;
    bit  drain_next   = 1'b0;

    int         gap_left   = 0;
    bit         tx_steady  = 1'b0;
    int         stall_left = 0;
    bit         rx_steady  = 1'b0;
    char_item_t next_item;
    eval_result_t got_want;

    prefix_expression_stack_evaluator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .character  (character),
        .is_last    (is_last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .value      (value),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [RES_W-1:0] trunc_div(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
        logic [RES_W-1:0] ma;
        logic [RES_W-1:0] mb;
        logic [RES_W-1:0] q;
        ma = a[RES_W-1] ? -a : a;
        mb = b[RES_W-1] ? -b : b;
        q  = ma / mb;
        return (a[RES_W-1] ^ b[RES_W-1]) ? -q : q;
    endfunction

    function automatic logic [RES_W-1:0] int_pow(logic [RES_W-1:0] bs_in, logic [RES_W-1:0] ex);
        logic [RES_W-1:0] bs;
        logic [RES_W-1:0] acc;
        logic [RES_W-1:0] e;
        bs  = bs_in;
        acc = 1;
        e   = ex;
        // A negative exponent gives 0 unless the base is 1 or -1.
        if (ex[RES_W-1])
        begin
            if (bs == 1)
                return 1;
            if (bs == '1)
                return ex[0] ? '1 : 1;
            return 0;
        end
        while (e != 0)
        begin
            if (e[0])
                acc = acc * bs;
            bs = bs * bs;
            e  = e >> 1;
        end
        return acc;
    endfunction

    task automatic predict_char(input logic [CHAR_W-1:0] c, input logic last);
        logic [RES_W-1:0] a;
        logic [RES_W-1:0] b;
        logic [RES_W-1:0] r;
        eval_result_t     res;
        if (shadow_error == ST_OK)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (shadow_count >= DEPTH)
                    shadow_error = ST_OVF;
                else
                begin
                    shadow_stack[shadow_count] = RES_W'(c - CH_ZERO);
                    shadow_count++;
                end
            end
            else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV || c == CH_POW)
            begin
                if (shadow_count < 2)
                    shadow_error = ST_BAD;
                else
                begin
                    a = shadow_stack[shadow_count-1];
                    b = shadow_stack[shadow_count-2];
                    shadow_count -= 2;
                    if (c == CH_DIV && b == 0)
                        shadow_error = ST_DIVZ;
                    else
                    begin
                        case (c)
                            CH_PLUS:  r = a + b;
                            CH_MINUS: r = a - b;
                            CH_MUL:   r = a * b;
                            CH_DIV:   r = trunc_div(a, b);
                            default:  r = int_pow(a, b);
                        endcase
                        shadow_stack[shadow_count] = r;
                        shadow_count++;
                    end
                end
            end
            else
                shadow_error = ST_BAD;
        end
        if (last)
        begin
            if (shadow_error == ST_OK && shadow_count != 1)
                shadow_error = ST_BAD;
            res.value  = (shadow_error == ST_OK) ? shadow_stack[0] : '0;
            res.status = shadow_error;
            expected_results.push_back(res);
            shadow_count = 0;
            shadow_error = ST_OK;
        end
    endtask

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Driver: one transaction per character, with random idle gaps between them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && !char_stall)
                predict_char(character, is_last);
            if (!char_valid || !char_stall)
            begin
                if (gap_left > 0)
                begin
                    char_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end
                else if (pending_chars.size() > 0 &&
                         !(pending_chars[0].drain && expected_results.size() != 0))
                begin
                    next_item  = pending_chars.pop_front();
                    char_valid <= 1'b1;
                    character  <= next_item.ch;
                    is_last    <= next_item.last;
                    gap_left   <= pick_gap(tx_steady);
                    if ($urandom_range(0, 149) == 0)
                        tx_steady <= !tx_steady;
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: value %0d, status %0d", value, status);
                    errors++;
                end
                else
                begin
                    got_want = expected_results.pop_front();
                    if (value !== got_want.value)
                    begin
                        $error("value: expected %0d, actual %0d", $signed(got_want.value), value);
                        errors++;
                    end
                    if (status !== got_want.status)
                    begin
                        $error("status: expected %0d, actual %0d", got_want.status, status);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_steady <= !rx_steady;
            end
            if (stall_left > 0)
            begin
                res_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!rx_steady && $urandom_range(0, 99) < 15)
            begin
                res_stall  <= 1'b1;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 2);
            end
            else
                res_stall <= 1'b0;
        end
    end

    task automatic add_char(input logic [CHAR_W-1:0] c, input logic last);
        char_item_t item;
        item.ch    = c;
        item.last  = last;
        item.drain = drain_next;
        drain_next = 1'b0;
        pending_chars.push_back(item);
    endtask

    // The expression is written left to right; it goes out right to left.
    task automatic add_bytes(input char_q_t q);
        for (int i = q.size() - 1; i >= 0; i--)
            add_char(q[i], i == 0);
        queued_chars += q.size();
    endtask

    function automatic char_q_t to_bytes(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    task automatic add_expr(input string s);
        add_bytes(to_bytes(s));
    endtask

    function automatic logic [CHAR_W-1:0] pick_op(int hi);
        case ($urandom_range(0, hi))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic string gen_expr(int d);
        string l;
        string r;
        if (d == 0 || $urandom_range(0, 3) == 0)
            return $sformatf("%c", pick_digit());
        l = gen_expr(d - 1);
        r = gen_expr(d - 1);
        return $sformatf("%c%s%s", pick_op(4), l, r);
    endfunction

    task automatic add_special();
        case ($urandom_range(0, 9))
            0: add_expr("/^2+9+9+94-01");   // most negative value divided by minus one
            1: add_expr("^2-01");
            2: add_expr("^1-01");
            3: add_expr("^-01-01");
            4: add_expr("^-01-02");
            5: add_expr("^00");
            6: add_expr("/50");
            7: add_expr("-^2+9+9+94-*99");
            8: add_expr("12");
            default: add_expr("+9");
        endcase
    endtask

    task automatic add_broken();
        char_q_t q;
        int      pos;
        q   = to_bytes(gen_expr($urandom_range(1, 4)));
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 3))
            0: q[pos] = CHAR_W'($urandom_range(0, 255));
            1: if (q.size() > 1) q.delete(pos);
            2: q.insert(pos, pick_digit());
            default: q.insert(pos, pick_op(4));
        endcase
        add_bytes(q);
    endtask

    // Left-nested chain: every digit is stacked before the first operator.
    task automatic add_deep(input bit overflow);
        char_q_t q;
        int      n_digits;
        n_digits = overflow ? DEPTH + 1 : DEPTH;
        for (int i = 0; i < n_digits - 1; i++)
            q.push_back(pick_op(2));
        for (int i = 0; i < n_digits; i++)
            q.push_back(pick_digit());
        add_bytes(q);
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            add_char(CHAR_W'($urandom_range(0, 255)),
                     (i == n - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 7) == 0));
        queued_chars += n;
    endtask

    initial
    begin
        int r;
        int next_drain;
        int rand_start;

        rst_n = 1'b0;

        add_char(8'h00, 1'b1);
        add_char(8'hFF, 1'b1);
        add_expr("9");
        add_expr("+");
        add_expr("+34");
        add_expr("-12");
        add_expr("*98");
        add_expr("/72");
        add_expr("^23");
        add_expr("/50");
        add_expr("12");
        add_expr("^0-01");
        add_deep(1'b0);
        add_deep(1'b1);

        rand_start = queued_chars;
        next_drain = queued_chars;
        while (queued_chars < rand_start + RAND_CHARS)
        begin
            if (queued_chars >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
            r = $urandom_range(0, 199);
            if (r < 130)
                add_expr(gen_expr($urandom_range(0, 4)));
            else if (r < 150)
                add_special();
            else if (r < 178)
                add_broken();
            else if (r < 196)
                add_noise();
            else
                add_deep(r[0]);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || char_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("prefix_expression_stack_evaluator: match");
        else
            $display("prefix_expression_stack_evaluator: mismatch");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("prefix_expression_stack_evaluator: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
